// ===== rtl/utfg_pkg.sv =====
// ----------------------------------------------------------------------------
// utfg_pkg
// Shared constants and helpers for the UDP test frame generator.
// ----------------------------------------------------------------------------
package utfg_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CfgFrameLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMacOverride = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDestMac = 2'd2;

  localparam int unsigned HdrBytes = 42;
  localparam int unsigned EthBytes = 14;
  localparam int unsigned UdpOff = 34;
  localparam int unsigned HdrBeats = 6;
  localparam int unsigned LenRawW = 10;

  localparam logic [9:0] ResetFrameLength = 10'd60;

  localparam logic [31:0] SrcIpBase = 32'h0A00_0000;
  localparam logic [31:0] DstIp = 32'hC0A8_0001;
  localparam logic [15:0] IpIdent = 16'd2012;
  localparam logic [15:0] UdpSrcPort = 16'd2012;
  localparam logic [15:0] UdpDstPort = 16'd3000;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0] IpVerIhl = 8'h45;
  localparam logic [7:0] IpTtl = 8'd64;
  localparam logic [7:0] IpProtoUdp = 8'd17;
  localparam logic [47:0] DefDstMac = 48'h00_01_02_03_04_05;
  localparam logic [47:0] SrcMac = 48'h06_07_08_09_0A_0B;

  // fixed words of the IPv4 header sum: ver/ihl/tos, id, ttl/proto, dst ip
  localparam logic [18:0] IpSumConst = 19'({IpVerIhl, 8'h00}) + 19'(IpIdent)
                                     + 19'({IpTtl, IpProtoUdp})
                                     + 19'(DstIp[31:16]) + 19'(DstIp[15:0]);
  // pseudo-header protocol, dst ip, both ports
  localparam logic [18:0] UdpSumConst = 19'(IpProtoUdp) + 19'(DstIp[31:16])
                                      + 19'(DstIp[15:0]) + 19'(UdpSrcPort)
                                      + 19'(UdpDstPort);

  // end-around carry fold of a wide sum into 16 bits
  function automatic logic [15:0] oc_fold(input logic [18:0] s);
    logic [16:0] t;
    logic [16:0] r;
    t = 17'(s[15:0]) + 17'(s[18:16]);
    r = 17'(t[15:0]) + 17'(t[16]);
    return r[15:0];
  endfunction

endpackage

// ===== rtl/udp_test_frame_generator.sv =====
// ----------------------------------------------------------------------------
// udp_test_frame_generator
// Builds one Ethernet/IPv4/UDP test frame per packet index, 8 bytes a beat.
// ----------------------------------------------------------------------------
// Stages: input register, generator stage, then the output register.
// Throughput: one 64-bit beat per cycle from the beat counter while the output
// is not stalled; the next item is taken while the current frame drains.
// Reset: clears all valids; frame_length 60, override off, dest MAC zero.
module udp_test_frame_generator #(
  parameter int unsigned MAX_FRAME_BYTES = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [utfg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [utfg_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [31:0]                       s_tdata_i,   // packet_index
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [71:0]                       m_tdata_o,   // beat_data, beat_bytes
  output logic                              m_tlast_o    // last_beat
);

  localparam int unsigned LenW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned BeatW = $clog2((MAX_FRAME_BYTES + 7) / 8);

  // configuration
  logic [LenW-1:0] len_q;
  logic            ovr_q;
  logic [47:0]     dmac_q;
  logic [utfg_pkg::LenRawW-1:0] len_raw;
  logic [LenW-1:0] len_clamp;

  assign len_raw = cfg_data_i[utfg_pkg::LenRawW-1:0];

  always_comb begin
    if (len_raw < utfg_pkg::LenRawW'(utfg_pkg::HdrBytes)) begin
      len_clamp = LenW'(utfg_pkg::HdrBytes);
    end else if (len_raw > utfg_pkg::LenRawW'(MAX_FRAME_BYTES)) begin
      len_clamp = LenW'(MAX_FRAME_BYTES);
    end else begin
      len_clamp = LenW'(len_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenW'(utfg_pkg::ResetFrameLength);
      ovr_q  <= 1'b0;
      dmac_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        utfg_pkg::CfgFrameLength: len_q  <= len_clamp;
        utfg_pkg::CfgMacOverride: ovr_q  <= cfg_data_i[0];
        utfg_pkg::CfgDestMac:     dmac_q <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        in_valid_q;
  logic [31:0] in_src_q;
  logic [31:0] src_sum;
  logic [31:0] src_d;

  // generator stage
  logic             gen_act_q;
  logic [BeatW-1:0] gen_beat_q;
  logic [31:0]      gen_src_q;
  logic [15:0]      gen_ipck_q;
  logic [15:0]      gen_udpck_q;

  // output register
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic [3:0]  out_bytes_q;
  logic        out_last_q;

  logic out_ready;
  logic gen_fire;
  logic gen_last;
  logic gen_free;
  logic load_gen;
  logic in_fire;

  assign src_sum = utfg_pkg::SrcIpBase + s_tdata_i;
  assign src_d   = (src_sum == 32'hFFFF_FFFF) ? 32'h0 : src_sum;

  assign out_ready  = !out_valid_q || m_tready_i;
  assign gen_fire   = gen_act_q && out_ready;
  assign gen_free   = !gen_act_q || (gen_fire && gen_last);
  assign load_gen   = in_valid_q && gen_free;
  assign s_tready_o = !in_valid_q || gen_free;
  assign in_fire    = s_tvalid_i && s_tready_o;

  // checksums for the item moving into the generator stage
  logic [15:0] ip_len;
  logic [15:0] udp_len;
  logic [18:0] ip_sum;
  logic [18:0] udp_sum;
  logic [15:0] ipck_d;
  logic [15:0] udpck_d;

  assign ip_len  = 16'(len_q) - 16'(utfg_pkg::EthBytes);
  assign udp_len = 16'(len_q) - 16'(utfg_pkg::UdpOff);
  assign ip_sum  = utfg_pkg::IpSumConst + 19'(ip_len)
                 + 19'(in_src_q[31:16]) + 19'(in_src_q[15:0]);
  assign udp_sum = utfg_pkg::UdpSumConst + 19'(udp_len) + 19'(udp_len)
                 + 19'(in_src_q[31:16]) + 19'(in_src_q[15:0]);
  assign ipck_d  = ~utfg_pkg::oc_fold(ip_sum);
  assign udpck_d = ~utfg_pkg::oc_fold(udp_sum);

  // header beats, beat 0 first
  logic [0:utfg_pkg::HdrBeats-1][63:0] hdr;
  logic [47:0] dmac;
  logic [2:0]  hdr_idx;
  logic [63:0] beat_data;
  logic [LenW-1:0] pos;
  logic [LenW-1:0] rem;
  logic [3:0]  beat_bytes;

  assign dmac = ovr_q ? dmac_q : utfg_pkg::DefDstMac;
  assign hdr = {dmac, utfg_pkg::SrcMac, utfg_pkg::EtherTypeIpv4,
                utfg_pkg::IpVerIhl, 8'h00, ip_len, utfg_pkg::IpIdent, 16'h0000,
                utfg_pkg::IpTtl, utfg_pkg::IpProtoUdp, gen_ipck_q,
                gen_src_q, utfg_pkg::DstIp,
                utfg_pkg::UdpSrcPort, utfg_pkg::UdpDstPort, udp_len, gen_udpck_q,
                48'h0};

  assign hdr_idx   = gen_beat_q[2:0];
  assign beat_data = (gen_beat_q < BeatW'(utfg_pkg::HdrBeats)) ? hdr[hdr_idx] : 64'h0;
  assign pos       = LenW'({gen_beat_q, 3'b000});
  assign rem       = len_q - pos;
  assign gen_last  = rem <= LenW'(8);
  assign beat_bytes = gen_last ? rem[3:0] : 4'd8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      gen_act_q   <= 1'b0;
      gen_beat_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (load_gen) begin
        in_valid_q <= 1'b0;
      end
      if (load_gen) begin
        gen_act_q  <= 1'b1;
        gen_beat_q <= '0;
      end else if (gen_fire) begin
        if (gen_last) begin
          gen_act_q <= 1'b0;
        end
        gen_beat_q <= gen_beat_q + BeatW'(1);
      end
      if (out_ready) begin
        out_valid_q <= gen_act_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_src_q <= src_d;
    end
    if (load_gen) begin
      gen_src_q   <= in_src_q;
      gen_ipck_q  <= ipck_d;
      gen_udpck_q <= udpck_d;
    end
    if (gen_fire) begin
      out_data_q  <= beat_data;
      out_bytes_q <= beat_bytes;
      out_last_q  <= gen_last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'h0, out_bytes_q, out_data_q};
  assign m_tlast_o  = out_last_q;

  // checks
  a_beat_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_gen |=> gen_act_q && gen_beat_q == '0)
    else $error("beat counter not restarted on frame load");

  a_full_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tlast_o |-> m_tdata_o[67:64] == 4'd8)
    else $error("non-final beat not full");

  a_last_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> m_tdata_o[67:64] != 4'd0 && m_tdata_o[67:64] <= 4'd8)
    else $error("final beat byte count out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> in_valid_q && gen_act_q)
    else $error("input stalled with free stage");

endmodule

// ===== test/udp_test_frame_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// udp_test_frame_generator_tb
// Checks every output beat of the test frame generator against frames built
// here byte by byte: MACs, IPv4 and UDP headers, both checksums, beat byte
// counts and the last flag. Runs directed corner items and then random
// indices under many frame length and MAC settings, with random gaps on
// both streams and one long output stall.
// ----------------------------------------------------------------------------
module udp_test_frame_generator_tb;

  localparam int unsigned MaxFrame = 512;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam logic [utfg_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  localparam logic [31:0] IpBase = 32'h0A00_0000;
  localparam logic [31:0] IpDest = 32'hC0A8_0001;
  localparam logic [15:0] PortSrc = 16'd2012;
  localparam logic [15:0] PortDst = 16'd3000;
  localparam logic [15:0] IpId = 16'd2012;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } beat_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [utfg_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [utfg_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          s_tvalid_i = 1'b0;
  logic                          s_tready_o;
  logic [31:0]                   s_tdata_i = '0;
  logic                          m_tvalid_o;
  logic                          m_tready_i = 1'b0;
  logic [71:0]                   m_tdata_o;
  logic                          m_tlast_o;

  // register copy, kept in step with the write port
  logic [9:0]  cfg_len = 10'd60;
  logic        cfg_ovr = 1'b0;
  logic [47:0] cfg_mac = '0;

  logic [7:0]  frame_buf [MaxFrame];
  logic [31:0] index_q [$];
  beat_t       beats_due_q [$];

  int unsigned items_offered = 0;
  int unsigned items_taken = 0;
  int unsigned beats_seen = 0;
  int unsigned zero_csum_frames = 0;
  int unsigned settings_run = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_served = 0;
  logic        no_gaps = 1'b0;

  udp_test_frame_generator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned oc_add(input int unsigned s, input logic [15:0] v);
    s = s + 32'(v);
    if (s > 32'hFFFF) s = s - 32'hFFFF;
    return s;
  endfunction

  function automatic int unsigned oc_span(input int unsigned from, input int unsigned n,
                                          input int unsigned s);
    int unsigned i;
    for (i = 0; i + 1 < n; i += 2) s = oc_add(s, {frame_buf[from+i], frame_buf[from+i+1]});
    if (i < n) s = oc_add(s, {frame_buf[from+i], 8'h00});
    return s;
  endfunction

  function automatic void put16(input int unsigned p, input logic [15:0] v);
    frame_buf[p] = v[15:8];
    frame_buf[p+1] = v[7:0];
  endfunction

  // fills frame_buf for one packet index, returns the frame length in bytes
  function automatic int unsigned build_frame(input logic [31:0] idx);
    int unsigned len;
    int unsigned udp_len;
    int unsigned s;
    logic [31:0] src;
    len = 32'(cfg_len);
    if (len > MaxFrame) len = MaxFrame;
    if (len < 42) len = 42;
    src = IpBase + idx;
    if (src == 32'hFFFF_FFFF) src = '0;
    udp_len = len - 34;
    for (int k = 0; k < MaxFrame; k++) frame_buf[k] = 8'h00;
    for (int k = 0; k < 12; k++) frame_buf[k] = 8'(k);
    if (cfg_ovr) for (int k = 0; k < 6; k++) frame_buf[k] = cfg_mac[47-8*k -: 8];
    put16(12, 16'h0800);
    frame_buf[14] = 8'h45;
    put16(16, 16'(len - 14));
    put16(18, IpId);
    frame_buf[22] = 8'd64;
    frame_buf[23] = 8'd17;
    put16(26, src[31:16]);
    put16(28, src[15:0]);
    put16(30, IpDest[31:16]);
    put16(32, IpDest[15:0]);
    s = oc_span(14, 20, 0);
    put16(24, 16'(~s));
    put16(34, PortSrc);
    put16(36, PortDst);
    put16(38, 16'(udp_len));
    s = oc_span(26, 8, 17 + udp_len);
    s = oc_span(42, len - 42, s);
    s = oc_span(34, 8, s);
    put16(40, 16'(~s));
    return len;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH beat %0d %s: got %h want %h", beats_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // monitor: register copy, frame prediction, beat checking
  always @(posedge clk_i) begin
    int unsigned len;
    int unsigned cnt;
    beat_t b;
    beat_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          utfg_pkg::CfgFrameLength: cfg_len = cfg_data_i[9:0];
          utfg_pkg::CfgMacOverride: cfg_ovr = cfg_data_i[0];
          utfg_pkg::CfgDestMac:     cfg_mac = cfg_data_i[47:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_o) begin
        items_taken++;
        len = build_frame(s_tdata_i);
        if (frame_buf[40] == 8'h00 && frame_buf[41] == 8'h00) zero_csum_frames++;
        for (int unsigned pos = 0; pos < len; pos += 8) begin
          cnt = (len - pos > 8) ? 8 : len - pos;
          b.data = '0;
          for (int unsigned k = 0; k < 8; k++)
            b.data = {b.data[55:0], (k < cnt) ? frame_buf[pos+k] : 8'h00};
          b.nbytes = 4'(cnt);
          b.last = (pos + 8 >= len);
          beats_due_q.push_back(b);
        end
      end
      if (m_tvalid_o && m_tready_i) begin
        beats_seen++;
        if (beats_due_q.size() == 0) begin
          flag_mismatch("unexpected beat", m_tdata_o[63:0], '0);
        end else begin
          want = beats_due_q.pop_front();
          if (m_tdata_o[63:0] !== want.data)
            flag_mismatch("beat_data", m_tdata_o[63:0], want.data);
          if (m_tdata_o[67:64] !== want.nbytes)
            flag_mismatch("beat_bytes", 64'(m_tdata_o[67:64]), 64'(want.nbytes));
          if (m_tlast_o !== want.last)
            flag_mismatch("last_beat", 64'(m_tlast_o), 64'(want.last));
        end
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && items_taken == items_offered) begin
      if (index_q.size() != 0 && (no_gaps || $urandom_range(99) >= 36)) begin
        s_tvalid_i <= 1'b1;
        s_tdata_i <= index_q.pop_front();
        items_offered++;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // long output stall, armed from the stimulus
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_served) begin
      hold_left <= HoldCycles;
      hold_served <= hold_req;
    end
  end

  always @(negedge clk_i) begin
    m_tready_i <= rst_ni && hold_left == 0 && (no_gaps || $urandom_range(99) >= 36);
  end

  task automatic write_reg(input logic [utfg_pkg::CfgIdxW-1:0] idx,
                           input logic [utfg_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_cfg(input logic [9:0] len, input logic ovr, input logic [47:0] mac);
    write_reg(utfg_pkg::CfgFrameLength, utfg_pkg::CfgDataW'(len));
    write_reg(utfg_pkg::CfgMacOverride, utfg_pkg::CfgDataW'(ovr));
    write_reg(utfg_pkg::CfgDestMac, mac);
    end_writes();
    settings_run++;
  endtask

  task automatic drain();
    while (!(index_q.size() == 0 && items_taken == items_offered &&
             beats_due_q.size() == 0))
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] zero_idx;
    logic [9:0]  len;
    logic [47:0] mac;
    int unsigned n;
    int unsigned rnd_items;
    int unsigned phase_no;
    logic        big;
    zero_idx = '0;
    rnd_items = 0;
    phase_no = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // out-of-range index must leave the reset settings alone
    write_reg(CfgUnused, '1);
    end_writes();

    // index whose UDP checksum comes out zero at the reset length
    for (int unsigned j = 0; j < (1 << 18); j++) begin
      n = build_frame(32'(j));
      if (frame_buf[40] == 8'h00 && frame_buf[41] == 8'h00) begin
        zero_idx = 32'(j);
        break;
      end
    end

    index_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hF5FF_FFFF, 32'hF5FF_FFFE,
                32'hF600_0000, 32'hAAAA_AAAA, 32'h5555_5555, zero_idx};
    drain();
    settings_run++;

    set_cfg(10'd0, 1'b1, '1);
    index_q = '{32'h0000_0001, 32'h8000_0000};
    drain();
    set_cfg(10'h3FF, 1'b1, '0);
    index_q = '{32'h1234_5678, 32'hF5FF_FFFF};
    drain();
    set_cfg(10'd512, 1'b0, 48'hA5C3_0F96_5A3C);
    index_q.push_back($urandom);
    drain();
    // short lengths: every fill of the final beat
    for (int unsigned l = 41; l <= 49; l++) begin
      set_cfg(10'(l), l[0], {16'($urandom), $urandom});
      index_q.push_back($urandom);
      drain();
    end

    while (rnd_items < 480) begin
      big = (phase_no != 1) && ($urandom_range(4) == 0);
      len = big ? 10'($urandom_range(131, 1023)) : 10'($urandom_range(0, 130));
      mac = {16'($urandom), $urandom};
      set_cfg(len, 1'($urandom_range(1)), mac);
      no_gaps = (phase_no == 2);
      n = big ? 6 : 40;
      for (int unsigned k = 0; k < n; k++) begin
        if ($urandom_range(7) == 0)
          index_q.push_back(32'hF5FF_FFFD + 32'($urandom_range(4)));
        else
          index_q.push_back($urandom);
      end
      if (phase_no == 1) hold_req++;
      rnd_items += n;
      phase_no++;
      drain();
    end
    no_gaps = 1'b0;

    repeat (20) @(posedge clk_i);
    $display("Covered %0d frames, %0d beats across %0d register settings",
             items_taken, beats_seen, settings_run);
    $display("Frames with a zero UDP checksum: %0d, leftover beats: %0d",
             zero_csum_frames, beats_due_q.size());
    if (errors == 0 && beats_due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/utfg_pkg.sv
rtl/udp_test_frame_generator.sv
test/udp_test_frame_generator_tb.sv
